[hdl/escape_sequence_decoder_assert.svh]
// Assertion macros of the escape sequence decoder result queue.
`ifndef ESCAPE_SEQUENCE_DECODER_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_ASSERT_SVH

// Expression must hold at every clock edge outside reset.
`define ESD_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ESD_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/esd_pkg.sv]
// Types and constants of the escape sequence decoder.
`timescale 1ns / 1ps

package esd_pkg;

   // Decoder modes
   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_CARET  = 3'd1,
      MODE_BSLASH = 3'd2,
      MODE_OCT1   = 3'd3,
      MODE_OCT2   = 3'd4
   } mode_type;

   // One decoded result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_end;
      logic       ended_at_stop;
      logic       last;
   } result_type;

   // All results caused by one input transaction (one or two)
   typedef struct packed {
      result_type r0;
      result_type r1;
      logic       two;
   } pair_type;

   // Result queue depth, in input transactions
   localparam int QUEUE_DEPTH = 2;

   // CSR map: register index is paddr[2]
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_STOP_CHAR = 1'b0;
   localparam logic [7:0] STOP_CHAR_RESET = 8'd32;

endpackage

[hdl/esd_decode.sv]
// Escape decode state machine: classifies one accepted character per cycle.
`timescale 1ns / 1ps

module esd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          stop_char,
   input  logic                accept,
   input  logic [7:0]          ch,
   output logic                push,
   output esd_pkg::pair_type   push_data
);

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CARET_BIAS  = 8'd64;

   esd_pkg::mode_type mode_ff, mode_in;
   logic [5:0]        accum_ff, accum_in;

   // fresh character handling (normal mode view of ch)
   logic                 fresh_emit;
   esd_pkg::result_type  fresh_res;
   esd_pkg::mode_type    fresh_mode;
   logic                 fresh_close;
   logic                 is_oct;
   logic                 emit0;
   esd_pkg::pair_type    pair;

   function automatic logic [7:0] escape_letter(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         8'h6E:   r = 8'd10;  // n
         8'h72:   r = 8'd13;  // r
         8'h74:   r = 8'd9;   // t
         8'h62:   r = 8'd8;   // b
         8'h66:   r = 8'd12;  // f
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic esd_pkg::result_type byte_res(input logic [7:0] b);
      esd_pkg::result_type r;
      r.out_byte      = b;
      r.is_end        = 1'b0;
      r.ended_at_stop = 1'b0;
      r.last          = 1'b0;
      return r;
   endfunction

   function automatic esd_pkg::result_type end_res(input logic at_stop);
      esd_pkg::result_type r;
      r.out_byte      = 8'd0;
      r.is_end        = 1'b1;
      r.ended_at_stop = at_stop;
      r.last          = 1'b0;
      return r;
   endfunction

   always_comb begin
      is_oct      = ch inside {[8'h30:8'h37]};
      fresh_emit  = 1'b1;
      fresh_close = 1'b0;
      fresh_mode  = esd_pkg::MODE_NORMAL;
      fresh_res   = byte_res(ch);
      // end of text wins over a stop character of zero
      if (ch == CHAR_NUL) begin
         fresh_close = 1'b1;
         fresh_res   = end_res(1'b0);
      end else if (ch == stop_char) begin
         fresh_close = 1'b1;
         fresh_res   = end_res(1'b1);
      end else if (ch == CHAR_CARET) begin
         fresh_emit = 1'b0;
         fresh_mode = esd_pkg::MODE_CARET;
      end else if (ch == CHAR_BSLASH) begin
         fresh_emit = 1'b0;
         fresh_mode = esd_pkg::MODE_BSLASH;
      end
   end

   // next state
   always_comb begin
      mode_in  = mode_ff;
      accum_in = accum_ff;
      case (mode_ff)
         esd_pkg::MODE_CARET: begin
            mode_in = esd_pkg::MODE_NORMAL;
            if (ch == CHAR_NUL) accum_in = 6'd0;
         end
         esd_pkg::MODE_BSLASH: begin
            if (ch == CHAR_NUL) begin
               mode_in  = esd_pkg::MODE_NORMAL;
               accum_in = 6'd0;
            end else if (is_oct) begin
               mode_in  = esd_pkg::MODE_OCT1;
               accum_in = {3'd0, ch[2:0]};
            end else begin
               mode_in = esd_pkg::MODE_NORMAL;
            end
         end
         esd_pkg::MODE_OCT1: begin
            if (is_oct) begin
               mode_in  = esd_pkg::MODE_OCT2;
               accum_in = {accum_ff[2:0], ch[2:0]};
            end else begin
               mode_in  = fresh_mode;
               accum_in = 6'd0;
            end
         end
         esd_pkg::MODE_OCT2: begin
            mode_in  = is_oct ? esd_pkg::MODE_NORMAL : fresh_mode;
            accum_in = 6'd0;
         end
         default: begin
            mode_in = fresh_mode;
            if (fresh_close) accum_in = 6'd0;
         end
      endcase
   end

   // outputs
   always_comb begin
      emit0   = 1'b0;
      pair.r0 = byte_res(ch);
      pair.r1 = fresh_res;
      pair.two = 1'b0;
      case (mode_ff)
         esd_pkg::MODE_CARET: begin
            emit0 = 1'b1;
            if (ch == CHAR_NUL) begin
               // caret at end of text: literal caret, then end marker
               pair.r0  = byte_res(CHAR_CARET);
               pair.r1  = end_res(1'b0);
               pair.two = 1'b1;
            end else begin
               pair.r0 = byte_res(ch - CARET_BIAS);
            end
         end
         esd_pkg::MODE_BSLASH: begin
            if (ch == CHAR_NUL) begin
               emit0   = 1'b1;
               pair.r0 = end_res(1'b0);
            end else if (!is_oct) begin
               emit0   = 1'b1;
               pair.r0 = byte_res(escape_letter(ch));
            end
         end
         esd_pkg::MODE_OCT1, esd_pkg::MODE_OCT2: begin
            if (is_oct) begin
               if (mode_ff == esd_pkg::MODE_OCT2) begin
                  emit0   = 1'b1;
                  pair.r0 = byte_res({accum_ff[4:0], ch[2:0]});
               end
            end else begin
               // run ended early: pending value, then ch as a fresh character
               emit0    = 1'b1;
               pair.r0  = byte_res({2'd0, accum_ff});
               pair.two = fresh_emit;
            end
         end
         default: begin
            emit0   = fresh_emit;
            pair.r0 = fresh_res;
         end
      endcase
      if (pair.two) pair.r1.last = 1'b1;
      else          pair.r0.last = 1'b1;
   end

   assign push      = accept && emit0;
   assign push_data = pair;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= esd_pkg::MODE_NORMAL;
         accum_ff <= 6'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
      end
   end

endmodule

[hdl/esd_queue.sv]
// Result queue of decoded pairs: one result per cycle while rsp_ready is high.
`timescale 1ns / 1ps

`include "escape_sequence_decoder_assert.svh"

module esd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  esd_pkg::pair_type    push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output esd_pkg::result_type  rsp_data
);

   localparam int QPTR_W = (esd_pkg::QUEUE_DEPTH > 1) ? $clog2(esd_pkg::QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(esd_pkg::QUEUE_DEPTH + 1);
   localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(esd_pkg::QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(esd_pkg::QUEUE_DEPTH);

   esd_pkg::pair_type  entry_ff [esd_pkg::QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               sub_ff, sub_in;

   esd_pkg::pair_type  head;
   logic               fire;
   logic               pop;

   assign head      = entry_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != '0);
   assign full      = (count_ff == CNT_FULL);
   assign rsp_data  = sub_ff ? head.r1 : head.r0;
   assign fire      = rsp_valid && rsp_ready;
   // an entry leaves when its final result goes out
   assign pop       = fire && (sub_ff || !head.two);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      sub_in    = sub_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         sub_in    = 1'b0;
      end else if (fire) begin
         sub_in = 1'b1;
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sub_ff    <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sub_ff    <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

   `ESD_ASSERT_ALWAYS(a_count_range, count_ff <= CNT_FULL, "queue count beyond depth")
   `ESD_ASSERT_IMPL(a_no_push_full, push, !full || pop, "push into full queue")
   `ESD_ASSERT_NEXT(a_pop_count, pop && !push, count_ff == $past(count_ff) - 1'b1, "pop count")
   `ESD_ASSERT_NEXT(a_second_half, fire && head.two && !sub_ff, sub_ff && rsp_valid, "pair split")

endmodule

[hdl/escape_sequence_decoder.sv]
// Top level of the escape sequence decoder: CSR, decode state machine, result queue.
`timescale 1ns / 1ps

// Usage
//   req channel: one raw character (req_ch) per transaction; 0 means end of text.
//   rsp channel: decoded results, one per transaction: a byte (rsp_is_end 0) or a
//     segment end marker (rsp_is_end 1, rsp_ended_at_stop tells stop character vs
//     end of text). rsp_last marks the final result caused by an input character.
//   An input causes zero, one or two results; escape prefixes and octal digits
//     are absorbed until the sequence completes.
//   Results are registered in the result queue before they appear on rsp.
//   Throughput: one input per cycle while the queue has room; the decode state
//     machine decides each character combinationally. The output side moves one
//     result per cycle while rsp_ready is high; a pair of results goes out in turn.
//   A two-entry result queue separates the sides: when the receiver stalls,
//     inputs keep being taken until the queue is full, then req_ready drops.
//   Reset (synchronous): decode mode normal, queue empty, stop_char = 32.
//   CSR: stop_char at byte address 0; write only while the block is idle.

module escape_sequence_decoder (
   input  logic                          clock,
   input  logic                          reset,
   // input channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_ch,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_is_end,
   output logic                          rsp_ended_at_stop,
   output logic                          rsp_last,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [esd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);

   logic [7:0]           stop_char_ff;
   logic                 csr_write;
   logic                 accept;
   logic                 push;
   logic                 full;
   esd_pkg::pair_type    push_data;
   esd_pkg::result_type  rsp_data;

   // CSR: register index is paddr[2]; low address bits are ignored
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == esd_pkg::CSR_STOP_CHAR) ? {24'd0, stop_char_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_char_ff <= esd_pkg::STOP_CHAR_RESET;
      end else if (csr_write && csr_paddr[2] == esd_pkg::CSR_STOP_CHAR) begin
         stop_char_ff <= csr_pwdata[7:0];
      end
   end

   // a transaction is taken whenever the queue has room
   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   esd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .stop_char (stop_char_ff),
      .accept    (accept),
      .ch        (req_ch),
      .push      (push),
      .push_data (push_data)
   );

   esd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_byte      = rsp_data.out_byte;
   assign rsp_is_end        = rsp_data.is_end;
   assign rsp_ended_at_stop = rsp_data.ended_at_stop;
   assign rsp_last          = rsp_data.last;

endmodule
